// File: rtl/rcc_pkg.sv
`default_nettype none

package rcc_pkg;

   localparam int unsigned COLOR_W    = 64;
   localparam int unsigned SCENARIO_W = 3;
   localparam int unsigned TRIM_W     = 8;

   typedef enum logic [SCENARIO_W-1:0] {
      SCEN_AGREE   = 3'd0,
      SCEN_DIFFER  = 3'd1,
      SCEN_FEW     = 3'd2,
      SCEN_MANY    = 3'd3,
      SCEN_TRIMMED = 3'd4,
      SCEN_NONE    = 3'd5
   } scenario_type;

endpackage

`default_nettype wire

// File: rtl/read_color_classifier_unit.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  color[63:0], last_kmer
// rsp_      out        rsp_valid/rsp_stall  scenario[2:0], mapped, component[63:0],
//                                           trim_start[7:0], trim_end[7:0]
//
// One request is taken every cycle while req_stall is low.
// The request register feeds a single stage that folds the k-mer into the read accumulators.
// Requests that are not the last of a read never wait for the result register.
// A last k-mer waits in the request register while a previous result is stalled.
// Synchronous reset clears the valid flags and the accumulators.

`default_nettype none

module read_color_classifier_unit
   import rcc_pkg::*;
#(
   parameter int unsigned MAX_KMERS = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COLOR_W-1:0]    req_color,
   input  wire logic                  req_last_kmer,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [SCENARIO_W-1:0]      rsp_scenario,
   output logic                       rsp_mapped,
   output logic [COLOR_W-1:0]         rsp_component,
   output logic [TRIM_W-1:0]          rsp_trim_start,
   output logic [TRIM_W-1:0]          rsp_trim_end
);

   localparam int unsigned IDX_W = $clog2(MAX_KMERS);
   localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_KMERS - 1);

   logic                  s1_valid_ff, s1_valid_in;
   logic [COLOR_W-1:0]    s1_color_ff;
   logic                  s1_last_ff;

   logic [COLOR_W-1:0]    first_color_ff, first_color_in;
   logic [IDX_W-1:0]      kmer_index_ff, kmer_index_in;
   logic [IDX_W-1:0]      found_count_ff, found_count_in;
   logic [COLOR_W-1:0]    seen_a_ff, seen_a_in;
   logic [COLOR_W-1:0]    seen_b_ff, seen_b_in;
   logic [1:0]            distinct_ff, distinct_in;
   logic [IDX_W-1:0]      first_nz_ff, first_nz_in;
   logic [IDX_W-1:0]      last_nz_ff, last_nz_in;
   logic                  any_nz_ff, any_nz_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   scenario_type          rsp_scenario_ff, rsp_scenario_in;
   logic                  rsp_mapped_ff, rsp_mapped_in;
   logic [COLOR_W-1:0]    rsp_component_ff, rsp_component_in;
   logic [TRIM_W-1:0]     rsp_trim_start_ff, rsp_trim_start_in;
   logic [TRIM_W-1:0]     rsp_trim_end_ff, rsp_trim_end_in;

   logic                  out_free;
   logic                  s1_advance;
   logic                  req_take;
   logic                  color_nz;
   logic [COLOR_W-1:0]    term_first;
   logic [IDX_W:0]        kmer_total;
   logic [IDX_W:0]        found_twice;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;
   assign color_nz   = (s1_color_ff != '0);

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !s1_advance);

      first_color_in = first_color_ff;
      kmer_index_in  = kmer_index_ff;
      found_count_in = found_count_ff;
      seen_a_in      = seen_a_ff;
      seen_b_in      = seen_b_ff;
      distinct_in    = distinct_ff;
      first_nz_in    = first_nz_ff;
      last_nz_in     = last_nz_ff;
      any_nz_in      = any_nz_ff;

      if (kmer_index_ff == '0) begin
         first_color_in = s1_color_ff;
      end
      if (color_nz) begin
         if (found_count_ff < IDX_LIMIT) begin
            found_count_in = found_count_ff + IDX_W'(1);
         end
         if (!any_nz_ff) begin
            first_nz_in = kmer_index_ff;
         end
         last_nz_in = kmer_index_ff;
         any_nz_in  = 1'b1;
      end
      unique case (distinct_ff)
         2'd0: begin
            seen_a_in   = s1_color_ff;
            distinct_in = 2'd1;
         end
         2'd1: begin
            if (s1_color_ff != seen_a_ff) begin
               seen_b_in   = s1_color_ff;
               distinct_in = 2'd2;
            end
         end
         2'd2: begin
            if (s1_color_ff != seen_a_ff && s1_color_ff != seen_b_ff) begin
               distinct_in = 2'd3;
            end
         end
         2'd3: begin
            distinct_in = 2'd3;
         end
      endcase

      term_first  = first_color_in;
      kmer_total  = {1'b0, kmer_index_ff} + (IDX_W + 1)'(1);
      found_twice = {found_count_in, 1'b0};

      rsp_mapped_in     = 1'b0;
      rsp_component_in  = '0;
      rsp_trim_start_in = '0;
      rsp_trim_end_in   = '0;
      priority if (term_first != '0 && color_nz) begin
         if (term_first == s1_color_ff) begin
            rsp_scenario_in  = SCEN_AGREE;
            rsp_mapped_in    = 1'b1;
            rsp_component_in = term_first;
         end else begin
            rsp_scenario_in = SCEN_DIFFER;
         end
      end else if (found_twice < kmer_total) begin
         rsp_scenario_in = SCEN_FEW;
      end else if (distinct_in == 2'd3) begin
         rsp_scenario_in = SCEN_MANY;
      end else if (distinct_in == 2'd2) begin
         rsp_scenario_in   = SCEN_TRIMMED;
         rsp_mapped_in     = 1'b1;
         rsp_component_in  = (seen_a_in != '0) ? seen_a_in : seen_b_in;
         rsp_trim_start_in = TRIM_W'(first_nz_in);
         rsp_trim_end_in   = TRIM_W'(last_nz_in);
      end else begin
         rsp_scenario_in = SCEN_NONE;
      end

      if (s1_last_ff) begin
         first_color_in = '0;
         kmer_index_in  = '0;
         found_count_in = '0;
         seen_a_in      = '0;
         seen_b_in      = '0;
         distinct_in    = '0;
         first_nz_in    = '0;
         last_nz_in     = '0;
         any_nz_in      = 1'b0;
      end else if (kmer_index_ff < IDX_LIMIT) begin
         kmer_index_in = kmer_index_ff + IDX_W'(1);
      end

      rsp_valid_in = (s1_advance && s1_last_ff) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         first_color_ff <= '0;
         kmer_index_ff  <= '0;
         found_count_ff <= '0;
         seen_a_ff      <= '0;
         seen_b_ff      <= '0;
         distinct_ff    <= '0;
         first_nz_ff    <= '0;
         last_nz_ff     <= '0;
         any_nz_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            first_color_ff <= first_color_in;
            kmer_index_ff  <= kmer_index_in;
            found_count_ff <= found_count_in;
            seen_a_ff      <= seen_a_in;
            seen_b_ff      <= seen_b_in;
            distinct_ff    <= distinct_in;
            first_nz_ff    <= first_nz_in;
            last_nz_ff     <= last_nz_in;
            any_nz_ff      <= any_nz_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_color_ff <= req_color;
         s1_last_ff  <= req_last_kmer;
      end
      if (s1_advance && s1_last_ff) begin
         rsp_scenario_ff   <= rsp_scenario_in;
         rsp_mapped_ff     <= rsp_mapped_in;
         rsp_component_ff  <= rsp_component_in;
         rsp_trim_start_ff <= rsp_trim_start_in;
         rsp_trim_end_ff   <= rsp_trim_end_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scenario   = rsp_scenario_ff;
   assign rsp_mapped     = rsp_mapped_ff;
   assign rsp_component  = rsp_component_ff;
   assign rsp_trim_start = rsp_trim_start_ff;
   assign rsp_trim_end   = rsp_trim_end_ff;

endmodule

`default_nettype wire

// File: rtl/rcc_checker.sv
`default_nettype none

module rcc_checker
   import rcc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  req_last_kmer,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [SCENARIO_W-1:0] rsp_scenario,
   input wire logic                  rsp_mapped,
   input wire logic [COLOR_W-1:0]    rsp_component,
   input wire logic [TRIM_W-1:0]     rsp_trim_start,
   input wire logic [TRIM_W-1:0]     rsp_trim_end
);

   // A mapped read names a nonzero component and one of the two mapping outcomes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mapped |->
         rsp_component != '0 &&
         (rsp_scenario == SCEN_AGREE || rsp_scenario == SCEN_TRIMMED))
      else $error("mapped result with bad component or scenario");

   // An unmapped read carries no component and no trim window.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mapped |->
         rsp_component == '0 && rsp_trim_start == '0 && rsp_trim_end == '0)
      else $error("unmapped result with nonzero payload");

   // A fresh result must trace back to an accepted last k-mer of a read.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_kmer, 2))
      else $error("result without a preceding last k-mer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_scenario) && $stable(rsp_mapped) &&
         $stable(rsp_component) && $stable(rsp_trim_start) && $stable(rsp_trim_end))
      else $error("stalled result changed");

endmodule

bind read_color_classifier_unit rcc_checker u_rcc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_last_kmer  (req_last_kmer),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_scenario   (rsp_scenario),
   .rsp_mapped     (rsp_mapped),
   .rsp_component  (rsp_component),
   .rsp_trim_start (rsp_trim_start),
   .rsp_trim_end   (rsp_trim_end)
);

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rcc_pkg::*;

   localparam int          PERIOD       = 20;
   localparam int          MAX_KMERS    = 256;
   localparam logic [7:0]  INDEX_LIMIT  = 8'(MAX_KMERS - 1);
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_ITEMS = 120;
   localparam int          HOLD_CYCLES  = 300;

   typedef struct {
      scenario_type       scenario;
      logic               mapped;
      logic [COLOR_W-1:0] component;
      logic [TRIM_W-1:0]  trim_start;
      logic [TRIM_W-1:0]  trim_end;
   } read_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [COLOR_W-1:0]    req_color = '0;
   logic                  req_last_kmer = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SCENARIO_W-1:0] rsp_scenario;
   logic                  rsp_mapped;
   logic [COLOR_W-1:0]    rsp_component;
   logic [TRIM_W-1:0]     rsp_trim_start;
   logic [TRIM_W-1:0]     rsp_trim_end;

   read_result_type expected_reads[$];

   logic [COLOR_W-1:0] rd_first_color = '0;
   logic [7:0]         rd_index = '0;
   logic [7:0]         rd_found = '0;
   logic [COLOR_W-1:0] rd_value_a = '0;
   logic [COLOR_W-1:0] rd_value_b = '0;
   logic [1:0]         rd_distinct = '0;
   logic [7:0]         rd_first_nz = '0;
   logic [7:0]         rd_last_nz = '0;
   logic               rd_any_nz = 1'b0;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;
   int cycles = 0;
   int failures = 0;
   int kmers_sent = 0;
   int reads_checked = 0;
   int scenario_hits[6] = '{default: 0};

   read_color_classifier_unit #(.MAX_KMERS(MAX_KMERS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_color      (req_color),
      .req_last_kmer  (req_last_kmer),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scenario   (rsp_scenario),
      .rsp_mapped     (rsp_mapped),
      .rsp_component  (rsp_component),
      .rsp_trim_start (rsp_trim_start),
      .rsp_trim_end   (rsp_trim_end)
   );

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("read_color_classifier_unit regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Folds one accepted k-mer into the running read state and, on the last
   // k-mer, queues the classification of the whole read.
   task automatic classify_kmer(input logic [COLOR_W-1:0] color, input logic is_last);
      logic [8:0]      kmer_total;
      read_result_type res;
      if (rd_index == 0)
         rd_first_color = color;
      if (color != 0) begin
         if (rd_found < INDEX_LIMIT)
            rd_found++;
         if (!rd_any_nz)
            rd_first_nz = rd_index;
         rd_last_nz = rd_index;
         rd_any_nz = 1'b1;
      end
      case (rd_distinct)
         2'd0: begin
            rd_value_a = color;
            rd_distinct = 2'd1;
         end
         2'd1: begin
            if (color != rd_value_a) begin
               rd_value_b = color;
               rd_distinct = 2'd2;
            end
         end
         2'd2: begin
            if (color != rd_value_a && color != rd_value_b)
               rd_distinct = 2'd3;
         end
         default: ;
      endcase
      if (!is_last) begin
         if (rd_index < INDEX_LIMIT)
            rd_index++;
      end else begin
         kmer_total = {1'b0, rd_index} + 9'd1;
         res.mapped = 1'b0;
         res.component = '0;
         res.trim_start = '0;
         res.trim_end = '0;
         if (rd_first_color != 0 && color != 0) begin
            if (rd_first_color == color) begin
               res.scenario = SCEN_AGREE;
               res.mapped = 1'b1;
               res.component = rd_first_color;
            end else begin
               res.scenario = SCEN_DIFFER;
            end
         end else if ({rd_found, 1'b0} < kmer_total) begin
            res.scenario = SCEN_FEW;
         end else if (rd_distinct == 2'd3) begin
            res.scenario = SCEN_MANY;
         end else if (rd_distinct == 2'd2) begin
            res.scenario = SCEN_TRIMMED;
            res.mapped = 1'b1;
            res.component = (rd_value_a != 0) ? rd_value_a : rd_value_b;
            res.trim_start = rd_first_nz;
            res.trim_end = rd_last_nz;
         end else begin
            res.scenario = SCEN_NONE;
         end
         expected_reads = {expected_reads, res};
         rd_first_color = '0;
         rd_index = '0;
         rd_found = '0;
         rd_value_a = '0;
         rd_value_b = '0;
         rd_distinct = '0;
         rd_first_nz = '0;
         rd_last_nz = '0;
         rd_any_nz = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      read_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reads.size() == 0) begin
            $error("result with no read outstanding: scenario %0d", rsp_scenario);
            failures++;
         end else begin
            want = expected_reads.pop_front();
            reads_checked++;
            scenario_hits[want.scenario]++;
            if (rsp_scenario !== want.scenario) begin
               $error("scenario: expected %0d, got %0d", want.scenario, rsp_scenario);
               failures++;
            end
            if (rsp_mapped !== want.mapped) begin
               $error("mapped: expected %0d, got %0d", want.mapped, rsp_mapped);
               failures++;
            end
            if (rsp_component !== want.component) begin
               $error("component: expected %h, got %h", want.component, rsp_component);
               failures++;
            end
            if (rsp_trim_start !== want.trim_start) begin
               $error("trim_start: expected %0d, got %0d", want.trim_start, rsp_trim_start);
               failures++;
            end
            if (rsp_trim_end !== want.trim_end) begin
               $error("trim_end: expected %0d, got %0d", want.trim_end, rsp_trim_end);
               failures++;
            end
         end
      end
   end

   task automatic send_kmer(input logic [COLOR_W-1:0] color, input logic is_last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_color <= color;
      req_last_kmer <= is_last;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      kmers_sent++;
      classify_kmer(color, is_last);
   endtask

   task automatic send_read(input logic [COLOR_W-1:0] colors[$]);
      foreach (colors[i])
         send_kmer(colors[i], i == colors.size() - 1);
   endtask

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(3))
         0: pick_color = COLOR_W'($urandom_range(1, 3));
         1: pick_color = '1;
         default: pick_color = {$urandom(), $urandom()};
      endcase
      if (pick_color == 0)
         pick_color = 64'd1;
   endfunction

   task automatic test_directed_reads();
      logic [COLOR_W-1:0] all_ones;
      all_ones = '1;
      send_read('{64'h0000_0000_0000_002a});
      send_read('{64'd0});
      send_read('{all_ones});
      send_read('{64'd5, 64'd9});
      send_read('{64'd0, 64'd0, 64'd5});
      send_read('{64'd0, 64'd5, 64'd5, 64'd7});
      send_read('{64'd0, 64'd5, 64'd5, 64'd0});
      send_read('{all_ones, all_ones});
   endtask

   task automatic test_long_reads();
      logic [COLOR_W-1:0] colors[$];
      int                 lengths[3] = '{256, 257, 300};
      foreach (lengths[k]) begin
         colors.delete();
         for (int i = 0; i < lengths[k]; i++)
            colors = {colors, ((i == 0 || i == lengths[k] - 1) ? 64'd0
                                                                : 64'hdead_beef_0000_0007)};
         send_read(colors);
      end
      colors.delete();
      for (int i = 0; i < 300; i++)
         colors = {colors, (i == 150 ? 64'd3 : 64'd0)};
      send_read(colors);
   endtask

   task automatic test_random_reads(input int sender_pct, input int receiver_pct);
      logic [COLOR_W-1:0] colors[$];
      logic [COLOR_W-1:0] main_color;
      logic [COLOR_W-1:0] alt_color;
      logic [COLOR_W-1:0] c;
      int                 stop_at;
      int                 len;
      int                 style;
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
      stop_at = kmers_sent + RANDOM_ITEMS;
      while (kmers_sent < stop_at) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         style = $urandom_range(4);
         main_color = pick_color();
         alt_color = pick_color();
         colors.delete();
         for (int i = 0; i < len; i++) begin
            case (style)
               0: c = main_color;
               1: c = ($urandom_range(3) == 0) ? 64'd0 : main_color;
               2: begin
                  case ($urandom_range(3))
                     0: c = 64'd0;
                     1: c = main_color;
                     2: c = alt_color;
                     default: c = pick_color();
                  endcase
               end
               3: c = ($urandom_range(3) == 0) ? main_color : 64'd0;
               default: c = ($urandom_range(4) == 0) ? 64'd0 : {$urandom(), $urandom()};
            endcase
            if ((i == 0 || i == len - 1) && style != 0 && $urandom_range(1) == 0)
               c = 64'd0;
            colors = {colors, c};
         end
         send_read(colors);
      end
   endtask

   task automatic test_result_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 1'b1;
      for (int r = 0; r < 8; r++)
         send_read('{pick_color(), 64'd0});
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (expected_reads.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d k-mers and checked %0d read classifications.", kmers_sent,
               reads_checked);
      $display("Outcomes: agree %0d, differ %0d, few %0d, many %0d, trimmed %0d.",
               scenario_hits[SCEN_AGREE], scenario_hits[SCEN_DIFFER], scenario_hits[SCEN_FEW],
               scenario_hits[SCEN_MANY], scenario_hits[SCEN_TRIMMED]);
      if (failures == 0 && expected_reads.size() == 0) begin
         $display("read_color_classifier_unit regression: pass");
      end else begin
         $display("read_color_classifier_unit regression: fail");
      end
      $finish;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_reads();
      test_long_reads();
      test_result_backpressure();
      test_random_reads(10, 73);
      test_random_reads(73, 10);
      test_random_reads(0, 0);
      finish_run();
   end

endmodule

`default_nettype wire
